// File: rtl/ckmt_pkg.sv
// Shared types, codes and constants for the coordinate-keyed mark table.
`default_nettype none
package ckmt_pkg;

	localparam int MARK_CAPACITY_DEF = 256;
	localparam int CFG_IDX_W         = 1;
	localparam int CFG_DATA_W        = 9;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_BEGIN  = 3'd2;
	localparam logic [2:0] OP_END    = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'd1;

	localparam logic [8:0]  MAP_HEIGHT_RST = 9'd66;
	localparam logic [8:0]  MAP_WIDTH_RST  = 9'd198;
	localparam logic [7:0]  DEFAULT_SYMBOL = 8'd42;
	localparam logic [31:0] REVISION_RST   = 32'd1;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] row;
		logic [7:0] column;
		logic [7:0] attribute_in;
		logic [7:0] symbol_in;
	} mark_in_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  attribute_out;
		logic [7:0]  symbol_out;
		logic [31:0] revision;
	} mark_out_t;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] column;
		logic [7:0] attribute;
		logic [7:0] symbol;
	} mark_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ctrl_state_t;

endpackage
`default_nettype wire

// File: rtl/ckmt_mem.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module ckmt_mem #(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [IDX_W-1:0]     waddr,
	input  wire ckmt_pkg::mark_entry_t wdata,
	input  wire logic                 re,
	input  wire logic [IDX_W-1:0]     raddr,
	output ckmt_pkg::mark_entry_t     rdata
);
	import ckmt_pkg::*;

	mark_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/ckmt_ctrl.sv
// Sequencer: linear key search over the entry store, update and revision logic.
`default_nettype none
module ckmt_ctrl #(
	parameter int MARK_CAPACITY = ckmt_pkg::MARK_CAPACITY_DEF,
	parameter int IDX_W = 8,
	parameter int CNT_W = 9
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire ckmt_pkg::mark_in_t    req,
	input  wire logic [8:0]            map_height,
	input  wire logic [8:0]            map_width,
	input  wire logic                  out_free,
	output logic                       res_valid,
	output ckmt_pkg::mark_out_t        res,
	output logic                       mem_we,
	output logic [IDX_W-1:0]           mem_waddr,
	output ckmt_pkg::mark_entry_t      mem_wdata,
	output logic                       mem_re,
	output logic [IDX_W-1:0]           mem_raddr,
	input  wire ckmt_pkg::mark_entry_t mem_rdata
);
	import ckmt_pkg::*;

	ctrl_state_t state_q, state_d;

	logic [2:0]       op_q;
	logic [7:0]       row_q, col_q, attr_q, sym_q;
	logic             inb_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             batch_q, batch_d;
	logic [31:0]      rev_q, rev_d;
	logic [CNT_W-1:0] issue_q;
	logic             pend_q;
	logic [IDX_W-1:0] pidx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [7:0]       hit_attr_q, hit_sym_q;

	logic        accept, key_ok, need_scan, match, scan_end, done_fire, bump;
	logic        issue;
	logic [31:0] rev_inc;

	assign accept    = req_valid && req_ready;
	assign key_ok    = ({1'b0, req.row} < map_height) && ({1'b0, req.column} < map_width);
	assign need_scan = (((req.opcode == OP_ADD) && key_ok) || (req.opcode == OP_LOOKUP))
		&& (count_q != '0);
	assign match     = pend_q && (mem_rdata.row == row_q) && (mem_rdata.column == col_q);
	assign scan_end  = !pend_q && (issue_q == count_q);
	assign issue     = (state_q == ST_SCAN) && !match && (issue_q < count_q);
	assign done_fire = (state_q == ST_DONE) && out_free;
	assign rev_inc   = ((rev_q + 32'd1) == 32'd0) ? 32'd1 : rev_q + 32'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = need_scan ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (match || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE);
		mem_re    = issue;
		mem_raddr = issue_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = hit_idx_q;
		mem_wdata = '{row: row_q, column: col_q, attribute: attr_q, symbol: sym_q};
		count_d   = count_q;
		batch_d   = batch_q;
		bump      = 1'b0;
		if (done_fire) begin
			case (op_q)
				OP_ADD: begin
					if (inb_q) begin
						if (hit_q) begin
							if ((hit_attr_q != attr_q) || (hit_sym_q != sym_q)) begin
								mem_we = 1'b1;
								bump   = !batch_q;
							end
						end else if (count_q < CNT_W'(MARK_CAPACITY)) begin
							mem_we    = 1'b1;
							mem_waddr = count_q[IDX_W-1:0];
							count_d   = count_q + CNT_W'(1);
							bump      = !batch_q;
						end
					end
				end
				OP_BEGIN: begin
					count_d = '0;
					batch_d = 1'b1;
				end
				OP_END: begin
					batch_d = 1'b0;
					bump    = batch_q;
				end
				OP_CLEAR: begin
					count_d = '0;
					batch_d = 1'b0;
					bump    = (count_q != '0) || batch_q;
				end
				default: ;
			endcase
		end
		rev_d     = bump ? rev_inc : rev_q;
		res_valid = done_fire;
		res.found         = (op_q == OP_LOOKUP) && hit_q;
		res.attribute_out = res.found ? hit_attr_q : 8'd0;
		res.symbol_out    = res.found ? hit_sym_q : 8'd0;
		res.revision      = rev_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			batch_q <= 1'b0;
			rev_q   <= REVISION_RST;
			pend_q  <= 1'b0;
			hit_q   <= 1'b0;
			issue_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			batch_q <= batch_d;
			rev_q   <= rev_d;
			pend_q  <= issue;
			if (accept) begin
				hit_q   <= 1'b0;
				issue_q <= '0;
			end else begin
				if (match) begin
					hit_q <= 1'b1;
				end
				if (issue) begin
					issue_q <= issue_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.opcode;
			row_q  <= req.row;
			col_q  <= req.column;
			attr_q <= req.attribute_in;
			sym_q  <= (req.symbol_in != 8'd0) ? req.symbol_in : DEFAULT_SYMBOL;
			inb_q  <= key_ok;
		end
		if (issue) begin
			pidx_q <= issue_q[IDX_W-1:0];
		end
		if (match) begin
			hit_idx_q  <= pidx_q;
			hit_attr_q <= mem_rdata.attribute;
			hit_sym_q  <= mem_rdata.symbol;
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MARK_CAPACITY))
		else $error("entry count beyond capacity");
	a_rev_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rev_q != 32'd0)
		else $error("revision is zero");
	a_write_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_DONE) && out_free)
		else $error("store written outside completion");
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= count_q))
		else $error("search ran past the filled entries");
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> $stable(count_q))
		else $error("entry count changed during search");

endmodule
`default_nettype wire

// File: rtl/coordinate_keyed_mark_table.sv
// Coordinate-keyed mark table: top level with configuration and result registers.
//
// Usage: request items (req_valid/req_ready, payload req) carry an opcode, a
// (row, column) key and attribute/symbol data. Each accepted item yields exactly
// one result item (rsp_valid/rsp_ready, payload rsp) with found flag, data and
// the revision after the item. Items are handled one at a time.
// Flow: items with no search (begin, end, clear, unused codes, out-of-bounds
// adds, and adds or lookups on an empty table) go straight from the idle state
// to the done state. Other adds and lookups walk the stored entries in order
// through the single read port of the entry store, one entry a cycle, until a
// hit or until every filled entry has been read.
// A new item is taken the cycle after a result enters the output register,
// even while that result still waits for rsp_ready.
// Stall: with the output register full and rsp_ready low the finished item
// waits in its final state; nothing is lost.
// Configuration: cfg_we with cfg_index 0 (map_height) or 1 (map_width) writes
// cfg_data at once; write only while idle.
// Reset (arst_n low): table empty, batch closed, revision 1, map_height 66,
// map_width 198. The entry store itself is not cleared; no sweep is needed.
`default_nettype none
module coordinate_keyed_mark_table #(
	parameter int MARK_CAPACITY = ckmt_pkg::MARK_CAPACITY_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire ckmt_pkg::mark_in_t                req,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output ckmt_pkg::mark_out_t                    rsp,
	input  wire logic                              cfg_we,
	input  wire logic [ckmt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ckmt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ckmt_pkg::*;

	localparam int IDX_W = (MARK_CAPACITY > 1) ? $clog2(MARK_CAPACITY) : 1;
	localparam int CNT_W = $clog2(MARK_CAPACITY + 1);

	logic [8:0]  map_height_q, map_width_q;
	logic        out_valid_q, out_free, res_valid;
	mark_out_t   out_item_q, res;
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	mark_entry_t      mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_height_q <= MAP_HEIGHT_RST;
			map_width_q  <= MAP_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_item_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_item_q;

	ckmt_ctrl #(
		.MARK_CAPACITY(MARK_CAPACITY),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.map_height(map_height_q),
		.map_width(map_width_q),
		.out_free(out_free),
		.res_valid(res_valid),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ckmt_mem #(
		.DEPTH(MARK_CAPACITY),
		.IDX_W(IDX_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
`default_nettype wire
